// ----- rtl/core/rtc_pkg.sv -----
`default_nettype none

package rtc_pkg;

  localparam int MAX_RADIX   = 16;
  localparam int NUM_CHARS   = 16;
  localparam int CHAR_W      = 8;
  localparam int ALPHA_W     = 64;
  localparam int RADIX_W     = 5;
  localparam int ACC_W       = 32;
  localparam int DIGIT_W     = 4;
  localparam int STORE_DEPTH = 32;
  localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W       = STORE_IDX_W + 1;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STEPS   = ACC_W / DIV_BITS;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FROM_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FROM_RDX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_LO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_HI    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TO_RDX   = 3'd5;

  localparam logic [ALPHA_W-1:0] ALPHA_LO_RST = 64'h3736_3534_3332_3130;
  localparam logic [ALPHA_W-1:0] ALPHA_HI_RST = 64'h0000_0000_0000_3938;
  localparam logic [RADIX_W-1:0] RADIX_RST    = 5'd10;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;

  typedef struct packed {
    logic take_byte;
    logic load;
    logic div_step;
    logic emit_digit;
    logic emit_err;
  } rtc_cmd_t;

  typedef struct packed {
    logic byte_zero;
    logic alpha_ok;
    logic div_finish;
    logic emit_last;
  } rtc_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/rtc_ctrl.sv -----
`default_nettype none

module rtc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire rtc_pkg::rtc_sts_t sts,
  output rtc_pkg::rtc_cmd_t      cmd
);

  typedef enum logic [2:0] {
    C_IDLE,
    C_CHECK,
    C_DIV,
    C_EMIT,
    C_ERR
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != C_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      C_IDLE: begin
        cmd.take_byte = in_valid;
        if (in_valid && sts.byte_zero) begin
          state_nxt = C_CHECK;
        end
      end
      C_CHECK: begin
        cmd.load  = 1'b1;
        state_nxt = sts.alpha_ok ? C_DIV : C_ERR;
      end
      C_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_finish) begin
          state_nxt = C_EMIT;
        end
      end
      C_EMIT: begin
        if (slot_free) begin
          cmd.emit_digit = 1'b1;
          out_valid_nxt  = 1'b1;
          if (sts.emit_last) begin
            state_nxt = C_IDLE;
          end
        end
      end
      C_ERR: begin
        if (slot_free) begin
          cmd.emit_err  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_zero_byte_checks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && sts.byte_zero) |=> (state_r == C_CHECK))
    else $error("terminating byte did not start the conversion");

  a_check_branches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_CHECK) |=> (state_r == C_DIV || state_r == C_ERR))
    else $error("alphabet check did not branch");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(cmd.emit_digit || cmd.emit_err))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- rtl/core/rtc_dp.sv -----
`default_nettype none

module rtc_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wen,
  input  wire logic [rtc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rtc_pkg::ALPHA_W-1:0]         cfg_wdata,
  input  wire logic [rtc_pkg::CHAR_W-1:0]          in_text_byte,
  input  wire rtc_pkg::rtc_cmd_t                   cmd,
  output rtc_pkg::rtc_sts_t                        sts,
  output logic [rtc_pkg::CHAR_W-1:0]               out_char,
  output logic                                     out_base_error,
  output logic                                     out_last
);

  typedef enum logic [1:0] {
    PH_WS,
    PH_SIGN,
    PH_DIGIT,
    PH_STOP
  } phase_t;

  function automatic logic [rtc_pkg::CHAR_W-1:0] alpha_char(
    input logic [rtc_pkg::ALPHA_W-1:0] lo,
    input logic [rtc_pkg::ALPHA_W-1:0] hi,
    input logic [rtc_pkg::DIGIT_W-1:0] k
  );
    logic [2*rtc_pkg::ALPHA_W-1:0] w;
    w = {hi, lo};
    return w[{k, 3'b000} +: rtc_pkg::CHAR_W];
  endfunction

  function automatic logic is_space(input logic [rtc_pkg::CHAR_W-1:0] c);
    return (c == rtc_pkg::CH_SPACE) || (c >= rtc_pkg::CH_TAB && c <= rtc_pkg::CH_CR);
  endfunction

  function automatic logic alpha_ok(
    input logic [rtc_pkg::ALPHA_W-1:0] lo,
    input logic [rtc_pkg::ALPHA_W-1:0] hi,
    input logic [rtc_pkg::RADIX_W-1:0] r
  );
    logic                        ok;
    logic [rtc_pkg::CHAR_W-1:0]  ci;
    logic [rtc_pkg::CHAR_W-1:0]  cj;
    ok = (r >= 5'd2) && (r <= rtc_pkg::RADIX_W'(rtc_pkg::MAX_RADIX));
    for (int i = 0; i < rtc_pkg::NUM_CHARS; i++) begin
      ci = alpha_char(lo, hi, rtc_pkg::DIGIT_W'(i));
      if (rtc_pkg::RADIX_W'(i) < r) begin
        if (ci == rtc_pkg::CH_NUL || ci == rtc_pkg::CH_PLUS ||
            ci == rtc_pkg::CH_MINUS || is_space(ci)) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < rtc_pkg::NUM_CHARS; j++) begin
          cj = alpha_char(lo, hi, rtc_pkg::DIGIT_W'(j));
          if (rtc_pkg::RADIX_W'(j) < r && cj == ci) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

  // configuration
  logic [rtc_pkg::ALPHA_W-1:0] from_lo_r, from_hi_r, to_lo_r, to_hi_r;
  logic [rtc_pkg::RADIX_W-1:0] from_rdx_r, to_rdx_r;

  // parse state
  phase_t                      phase_r, phase_nxt;
  logic                        parity_r, parity_nxt;
  logic [rtc_pkg::ACC_W-1:0]   acc_r, acc_nxt;

  // conversion state
  logic [rtc_pkg::ACC_W-1:0]   mag_r, mag_nxt;
  logic [rtc_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [rtc_pkg::STEP_W-1:0]  step_r;
  logic [rtc_pkg::CNT_W-1:0]   cnt_r;
  logic                        minus_pend_r;
  logic [rtc_pkg::DIGIT_W-1:0] store_r [rtc_pkg::STORE_DEPTH];

  logic [rtc_pkg::CHAR_W-1:0]  out_char_r;
  logic                        out_err_r, out_last_r;

  logic                        src_found;
  logic [rtc_pkg::DIGIT_W-1:0] src_idx;
  logic [rtc_pkg::ACC_W-1:0]   signed_val, load_mag;
  logic                        load_neg;
  logic                        div_last;
  logic [rtc_pkg::STORE_IDX_W-1:0] emit_idx;
  logic [rtc_pkg::CHAR_W-1:0]  emit_char;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_lo_r  <= rtc_pkg::ALPHA_LO_RST;
      from_hi_r  <= rtc_pkg::ALPHA_HI_RST;
      from_rdx_r <= rtc_pkg::RADIX_RST;
      to_lo_r    <= rtc_pkg::ALPHA_LO_RST;
      to_hi_r    <= rtc_pkg::ALPHA_HI_RST;
      to_rdx_r   <= rtc_pkg::RADIX_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        rtc_pkg::CFG_FROM_LO:  from_lo_r  <= cfg_wdata;
        rtc_pkg::CFG_FROM_HI:  from_hi_r  <= cfg_wdata;
        rtc_pkg::CFG_FROM_RDX: from_rdx_r <= cfg_wdata[rtc_pkg::RADIX_W-1:0];
        rtc_pkg::CFG_TO_LO:    to_lo_r    <= cfg_wdata;
        rtc_pkg::CFG_TO_HI:    to_hi_r    <= cfg_wdata;
        rtc_pkg::CFG_TO_RDX:   to_rdx_r   <= cfg_wdata[rtc_pkg::RADIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // lowest matching position wins
  always_comb begin
    src_found = 1'b0;
    src_idx   = '0;
    for (int i = rtc_pkg::NUM_CHARS - 1; i >= 0; i--) begin
      if (rtc_pkg::RADIX_W'(i) < from_rdx_r &&
          alpha_char(from_lo_r, from_hi_r, rtc_pkg::DIGIT_W'(i)) == in_text_byte) begin
        src_found = 1'b1;
        src_idx   = rtc_pkg::DIGIT_W'(i);
      end
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    parity_nxt = parity_r;
    acc_nxt    = acc_r;
    if (cmd.load) begin
      phase_nxt  = PH_WS;
      parity_nxt = 1'b0;
      acc_nxt    = '0;
    end else if (cmd.take_byte && in_text_byte != rtc_pkg::CH_NUL) begin
      priority if (phase_r == PH_STOP) begin
      end else if (phase_r == PH_WS && is_space(in_text_byte)) begin
      end else if (phase_r != PH_DIGIT &&
                   (in_text_byte == rtc_pkg::CH_PLUS || in_text_byte == rtc_pkg::CH_MINUS)) begin
        phase_nxt  = PH_SIGN;
        parity_nxt = parity_r ^ (in_text_byte == rtc_pkg::CH_MINUS);
      end else if (!src_found) begin
        phase_nxt = PH_STOP;
      end else begin
        phase_nxt = PH_DIGIT;
        acc_nxt   = acc_r * rtc_pkg::ACC_W'(from_rdx_r) + rtc_pkg::ACC_W'(src_idx);
      end
    end
  end

  assign signed_val = parity_r ? (~acc_r + 1'b1) : acc_r;
  assign load_neg   = signed_val[rtc_pkg::ACC_W-1];
  assign load_mag   = load_neg ? (~signed_val + 1'b1) : signed_val;

  // restoring division by the target radix, DIV_BITS quotient bits a cycle
  always_comb begin
    logic [rtc_pkg::DIGIT_W:0] rem_ext;
    mag_nxt = mag_r;
    rem_nxt = rem_r;
    for (int s = 0; s < rtc_pkg::DIV_BITS; s++) begin
      rem_ext = {rem_nxt, mag_nxt[rtc_pkg::ACC_W-1]};
      mag_nxt = {mag_nxt[rtc_pkg::ACC_W-2:0], 1'b0};
      if (rem_ext >= to_rdx_r) begin
        rem_nxt    = rtc_pkg::DIGIT_W'(rem_ext - to_rdx_r);
        mag_nxt[0] = 1'b1;
      end else begin
        rem_nxt = rem_ext[rtc_pkg::DIGIT_W-1:0];
      end
    end
  end

  assign div_last = (step_r == rtc_pkg::STEP_W'(rtc_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WS;
      parity_r     <= 1'b0;
      acc_r        <= '0;
      step_r       <= '0;
      cnt_r        <= '0;
      minus_pend_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      parity_r <= parity_nxt;
      acc_r    <= acc_nxt;
      if (cmd.load) begin
        step_r       <= '0;
        cnt_r        <= '0;
        minus_pend_r <= load_neg;
      end else if (cmd.div_step) begin
        if (div_last) begin
          step_r <= '0;
          cnt_r  <= cnt_r + 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end else if (cmd.emit_digit) begin
        if (minus_pend_r) begin
          minus_pend_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= load_mag;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      mag_r <= mag_nxt;
      rem_r <= div_last ? '0 : rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step && div_last) begin
      store_r[cnt_r[rtc_pkg::STORE_IDX_W-1:0]] <= rem_nxt;
    end
  end

  assign emit_idx  = rtc_pkg::STORE_IDX_W'(cnt_r - 1'b1);
  assign emit_char = alpha_char(to_lo_r, to_hi_r, store_r[emit_idx]);

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      out_char_r <= rtc_pkg::CH_NUL;
      out_err_r  <= 1'b1;
      out_last_r <= 1'b1;
    end else if (cmd.emit_digit) begin
      out_char_r <= minus_pend_r ? rtc_pkg::CH_MINUS : emit_char;
      out_err_r  <= 1'b0;
      out_last_r <= sts.emit_last;
    end
  end

  assign out_char       = out_char_r;
  assign out_base_error = out_err_r;
  assign out_last       = out_last_r;

  assign sts.byte_zero  = (in_text_byte == rtc_pkg::CH_NUL);
  assign sts.alpha_ok   = alpha_ok(from_lo_r, from_hi_r, from_rdx_r) &&
                          alpha_ok(to_lo_r, to_hi_r, to_rdx_r);
  assign sts.div_finish = div_last && (mag_nxt == '0 ||
                          cnt_r == rtc_pkg::CNT_W'(rtc_pkg::STORE_DEPTH - 1));
  assign sts.emit_last  = !minus_pend_r && (cnt_r == rtc_pkg::CNT_W'(1));

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rtc_pkg::CNT_W'(rtc_pkg::STORE_DEPTH))
    else $error("digit count beyond store depth");

  a_emit_written: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_digit && !minus_pend_r) |-> (cnt_r != '0))
    else $error("digit emitted from an empty store");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (cnt_r == '0 && step_r == '0 && phase_r == PH_WS && acc_r == '0))
    else $error("conversion start left stale state");

endmodule

`default_nettype wire

// ----- rtl/core/radix_text_converter.sv -----
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  in_text_byte
// out_      output     out_valid/out_stall  out_char, out_base_error, out_last
// cfg_      input      cfg_wen (no wait)    cfg_index, cfg_wdata
//
// a nonzero byte is parsed as it is taken, so text bytes transfer back to back
// the zero byte starts the alphabet check; on success the divider forms up to 32 target
// digits (the shared divider retires 4 quotient bits a cycle), then one output character
// is sent per cycle while out_stall is low; on failure a single error character is sent
// in_stall is high from the zero byte until the last character is registered
// rst_n is synchronous; it restores the default alphabets and clears the parse
`default_nettype none

module radix_text_converter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wen,
  input  wire logic [rtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rtc_pkg::ALPHA_W-1:0]   cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rtc_pkg::CHAR_W-1:0]    in_text_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rtc_pkg::CHAR_W-1:0]         out_char,
  output logic                               out_base_error,
  output logic                               out_last
);

  rtc_pkg::rtc_cmd_t cmd;
  rtc_pkg::rtc_sts_t sts;

  rtc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rtc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_text_byte   (in_text_byte),
    .cmd            (cmd),
    .sts            (sts),
    .out_char       (out_char),
    .out_base_error (out_base_error),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire
